// ===== src/rc4_stream_cipher_core_assert.svh =====
// Assertion macros for the RC4 keystream core, clocked on i_clk, held off in reset.
`ifndef RC4_STREAM_CIPHER_CORE_ASSERT_SVH
`define RC4_STREAM_CIPHER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RC4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rc4_pkg.sv =====
// Types and constants shared by the RC4 keystream core.
package rc4_pkg;

    localparam int unsigned S_AW  = 8;
    localparam int unsigned LEN_W = 9;

    localparam logic [LEN_W-1:0] KEY_LEN_RST = 9'd16;

    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_SCHED = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;

    typedef logic [7:0] t_byte;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RI,
        ST_KS_RJ,
        ST_KS_WI,
        ST_KS_WJ,
        ST_D_RX,
        ST_D_RY,
        ST_D_WX,
        ST_D_WY
    } t_state;

endpackage

// ===== src/rc4_stream_cipher_core.sv =====
// RC4 keystream core: key store, S-box memory, schedule and data sequencer.
//
// Input words arrive on the s_axis channel: tuser carries the mode, tdata the
// key index (bits 7:0) and the byte (bits 15:8). A key word writes one key byte
// in the cycle it is accepted. A schedule word fills the S-box with the
// identity and then mixes it with 256 swaps (read i, read j, write i, write
// j); it also clears both keystream indices. No word is taken during the
// schedule. A data word passes states D_RX, D_RY, D_WX and D_WY and then
// returns one byte on m_axis; a next data word is taken no earlier than D_WY,
// as the single S-box read port serves the reads of x, y and t and the write
// port the swap writes. Keys, schedule and mode-three words give no result.
// The result sits in an output register; while the receiver stalls with that
// register full, a further data word runs up to its second swap write, holds
// that write until the register drains, and input stays closed.
// Reset (i_rst_n low at a clock edge) clears the indices, the sequencer and
// the output valid, and sets the key length to 16. Key store and S-box keep
// their contents and must be written by key words and a schedule before use. The key
// length register is written via i_cfg_we / i_cfg_wdata; the user keeps that to idle.
`include "rc4_stream_cipher_core_assert.svh"

module rc4_stream_cipher_core #(
    parameter int unsigned KEY_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rc4_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // key_index[7:0], byte_in[15:8]
    input  logic [1:0]                  s_axis_tuser,  // mode[1:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata   // byte_out[7:0]
);
    import rc4_pkg::*;

    localparam int unsigned KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [LEN_W-1:0] KDEP = LEN_W'(KEY_DEPTH);

    t_state r_state, n_state;

    t_byte r_sbox [256];
    t_byte r_key [KEY_DEPTH];

    t_byte r_sb_q, r_byp_d, r_key_q;
    logic  r_byp;

    logic [LEN_W-1:0] r_key_len;
    logic [S_AW-1:0]  r_i, r_j, r_x, r_y;
    logic [KAW-1:0]   r_k;
    t_byte            r_si, r_sx, r_t, r_byte, r_odata;
    logic             r_ovalid;

    logic [1:0]       in_mode;
    t_byte            in_kidx, in_byte;
    logic             in_acc, out_free, key_ok, key_we;
    logic             sb_we, sb_re;
    logic [S_AW-1:0]  sb_wa, sb_ra;
    t_byte            sb_wd, sb_rd, ks_j, d_y, d_t, d_st;
    logic [LEN_W-1:0] len_eff, k_inc;

    assign in_mode  = s_axis_tuser;
    assign in_kidx  = s_axis_tdata[7:0];
    assign in_byte  = s_axis_tdata[15:8];
    assign out_free = !r_ovalid || m_axis_tready;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign key_ok   = {1'b0, in_kidx} < KDEP;
    assign key_we   = in_acc && (in_mode == MODE_KEY) && key_ok;

    assign sb_rd   = r_byp ? r_byp_d : r_sb_q;
    assign ks_j    = r_j + sb_rd + r_key_q;
    assign d_y     = r_y + sb_rd;
    assign d_t     = r_sx + sb_rd;
    assign d_st    = (r_t == r_y) ? r_sx : sb_rd;
    assign len_eff = (r_key_len == '0) ? LEN_W'(1) :
                     (r_key_len > KDEP) ? KDEP : r_key_len;
    assign k_inc   = {{(LEN_W-KAW){1'b0}}, r_k} + LEN_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_D_WY: begin
                if (r_state == ST_IDLE || out_free) begin
                    n_state = ST_IDLE;
                    if (in_acc) begin
                        case (in_mode)
                            MODE_SCHED: n_state = ST_FILL;
                            MODE_DATA:  n_state = ST_D_RX;
                            default:    n_state = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_FILL:  if (r_i == 8'hFF) n_state = ST_KS_RI;
            ST_KS_RI: n_state = ST_KS_RJ;
            ST_KS_RJ: n_state = ST_KS_WI;
            ST_KS_WI: n_state = ST_KS_WJ;
            ST_KS_WJ: n_state = (r_i == 8'hFF) ? ST_IDLE : ST_KS_RI;
            ST_D_RX:  n_state = ST_D_RY;
            ST_D_RY:  n_state = ST_D_WX;
            ST_D_WX:  n_state = ST_D_WY;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory controls and handshake
    always_comb begin
        sb_we         = 1'b0;
        sb_wa         = r_i;
        sb_wd         = r_i;
        sb_re         = 1'b0;
        sb_ra         = r_i;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_FILL:  sb_we = 1'b1;
            ST_KS_RI: sb_re = 1'b1;
            ST_KS_RJ: begin
                sb_re = 1'b1;
                sb_ra = ks_j;
            end
            ST_KS_WI: begin
                sb_we = 1'b1;
                sb_wd = sb_rd;
            end
            ST_KS_WJ: begin
                sb_we = 1'b1;
                sb_wa = r_j;
                sb_wd = r_si;
            end
            ST_D_RX: begin
                sb_re = 1'b1;
                sb_ra = r_x + 8'd1;
            end
            ST_D_RY: begin
                sb_re = 1'b1;
                sb_ra = d_y;
            end
            ST_D_WX: begin
                sb_we = 1'b1;
                sb_wa = r_x;
                sb_wd = sb_rd;
                sb_re = 1'b1;
                sb_ra = d_t;
            end
            ST_D_WY: begin
                sb_we         = out_free;
                sb_wa         = r_y;
                sb_wd         = r_sx;
                s_axis_tready = out_free;
            end
            default: ;
        endcase
    end

    // S-box memory with same-cycle write forwarding
    always_ff @(posedge i_clk) begin
        if (sb_we) begin
            r_sbox[sb_wa] <= sb_wd;
        end
        if (sb_re) begin
            r_sb_q  <= r_sbox[sb_ra];
            r_byp   <= sb_we && (sb_wa == sb_ra);
            r_byp_d <= sb_wd;
        end
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[in_kidx[KAW-1:0]] <= in_byte;
        end
        if (r_state == ST_KS_RI) begin
            r_key_q <= r_key[r_k];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_key_len <= KEY_LEN_RST;
            r_x       <= '0;
            r_y       <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_key_len <= i_cfg_wdata;
            end
            if (in_acc && in_mode == MODE_SCHED) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end
            case (r_state)
                ST_FILL:  r_i <= r_i + 8'd1;
                ST_KS_RJ: r_j <= ks_j;
                ST_KS_WJ: begin
                    r_i <= r_i + 8'd1;
                    r_k <= (k_inc >= len_eff) ? '0 : k_inc[KAW-1:0];
                    if (r_i == 8'hFF) begin
                        r_x <= '0;
                        r_y <= '0;
                    end
                end
                ST_D_RX:  r_x <= r_x + 8'd1;
                ST_D_RY:  r_y <= d_y;
                default: ;
            endcase
            if (r_state == ST_D_WY && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= in_byte;
        end
        if (r_state == ST_KS_RJ) begin
            r_si <= sb_rd;
        end
        if (r_state == ST_D_RY) begin
            r_sx <= sb_rd;
        end
        if (r_state == ST_D_WX) begin
            r_t <= d_t;
        end
        if (r_state == ST_D_WY && out_free) begin
            r_odata <= r_byte ^ d_st;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `RC4_ASSERT_NEXT(a_data_start, in_acc && in_mode == MODE_DATA, r_state == ST_D_RX,
        "data word did not start the sequencer")
    `RC4_ASSERT_NEXT(a_hold_result, r_state == ST_D_WY && !out_free, r_state == ST_D_WY,
        "pending result left while output register full")
    `RC4_ASSERT_NEXT(a_sched_end, r_state == ST_KS_WJ && r_i == 8'hFF,
        r_state == ST_IDLE && r_x == '0 && r_y == '0, "schedule end did not clear indices")
    `RC4_ASSERT_NOW(a_no_take_busy, r_state != ST_IDLE && r_state != ST_D_WY,
        !s_axis_tready, "input open while sequencer busy")

endmodule
